### rtl/core/acctw_pkg.sv
// Shared types and constants for the ANSI color text console writer.
// Holds the channel item structs, the queued job format and color constants.
// No dependencies.
package acctw_pkg;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [9:0] SGR_RESET   = 10'd0;
    localparam logic [9:0] SGR_RED     = 10'd31;
    localparam logic [9:0] SGR_GREEN   = 10'd32;
    localparam logic [9:0] SGR_YELLOW  = 10'd33;
    localparam logic [9:0] SGR_BLUE    = 10'd34;
    localparam logic [9:0] SGR_MAGENTA = 10'd35;
    localparam logic [9:0] SGR_CYAN    = 10'd36;
    localparam logic [9:0] SGR_WHITE   = 10'd37;
    localparam logic [9:0] NUM_MAX     = 10'd999;

    localparam logic [15:0] COLOR_RED    = 16'hFAAA;
    localparam logic [15:0] COLOR_YELLOW = 16'hFEAB;
    localparam logic [15:0] COLOR_BLUE   = 16'h5CBF;
    localparam logic [15:0] COLOR_CYAN   = 16'h66FF;

    localparam logic [15:0] WHITE_RESET     = 16'hFFFF;
    localparam logic [15:0] PRIMARY_RESET   = 16'h07FF;
    localparam logic [15:0] SECONDARY_RESET = 16'hF81F;

    localparam logic [1:0] REG_WHITE     = 2'd0;
    localparam logic [1:0] REG_PRIMARY   = 2'd1;
    localparam logic [1:0] REG_SECONDARY = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] OP_NEWLINE = 3'd0;
    localparam logic [2:0] OP_RETURN  = 3'd1;
    localparam logic [2:0] OP_TAB     = 3'd2;
    localparam logic [2:0] OP_BACK    = 3'd3;
    localparam logic [2:0] OP_PRINT   = 3'd4;

    typedef struct packed {
        logic [7:0]  char_in;
        logic [15:0] default_color;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [6:0]  column;
        logic [7:0]  glyph;
        logic [15:0] cell_color;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  glyph;
        logic [15:0] color;
        logic [15:0] fill;
    } t_job;

endpackage

### rtl/core/acctw_front.sv
// Front end: escape sequence parser, color state and configuration registers.
// Turns accepted characters into console jobs. Depends on acctw_pkg.
module acctw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_accept,
    input  acctw_pkg::t_in_item i_item,
    output logic               o_push,
    output acctw_pkg::t_job    o_job
);
    import acctw_pkg::*;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [9:0]  r_num, n_num;
    logic [15:0] r_color, n_color;
    logic [15:0] r_white, r_primary, r_secondary;

    logic        handle;
    logic        op_valid;
    logic [2:0]  op;
    logic [13:0] num_next;
    logic [7:0]  c;

    assign c = i_item.char_in;
    assign num_next = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0} + {10'd0, c[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_num   = r_num;
        n_color = r_color;
        handle  = 1'b0;
        case (r_phase)
            PH_TEXT: begin
                if (c == CH_ESC) begin
                    n_phase = PH_ESC;
                end else begin
                    handle = 1'b1;
                end
            end
            PH_ESC: begin
                if (c == CH_LBRK) begin
                    n_phase = PH_CSI;
                    n_num   = '0;
                end else begin
                    n_phase = PH_TEXT;
                    handle  = 1'b1;
                end
            end
            default: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    n_num = (num_next > 14'(NUM_MAX)) ? NUM_MAX : num_next[9:0];
                end else begin
                    n_phase = PH_TEXT;
                    if (c == CH_M) begin
                        case (r_num)
                            SGR_RESET, SGR_WHITE: n_color = r_white;
                            SGR_RED:              n_color = COLOR_RED;
                            SGR_GREEN:            n_color = r_primary;
                            SGR_YELLOW:           n_color = COLOR_YELLOW;
                            SGR_BLUE:             n_color = COLOR_BLUE;
                            SGR_MAGENTA:          n_color = r_secondary;
                            SGR_CYAN:             n_color = COLOR_CYAN;
                            default:              n_color = r_color;
                        endcase
                    end
                end
            end
        endcase
    end

    // Classify the character for the back end; other control bytes are dropped.
    always_comb begin
        op_valid = 1'b1;
        op       = OP_PRINT;
        if (c == CH_LF) begin
            op = OP_NEWLINE;
        end else if (c == CH_CR) begin
            op = OP_RETURN;
        end else if (c == CH_TAB) begin
            op = OP_TAB;
        end else if (c == CH_BS || c == CH_DEL) begin
            op = OP_BACK;
        end else if (c < CH_SPACE) begin
            op_valid = 1'b0;
        end
    end

    assign o_push      = i_accept && handle && op_valid;
    assign o_job.op    = op;
    assign o_job.glyph = (op == OP_TAB) ? CH_SPACE : c;
    assign o_job.color = (r_color != r_white) ? r_color : i_item.default_color;
    assign o_job.fill  = r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_num       <= '0;
            r_color     <= WHITE_RESET;
            r_white     <= WHITE_RESET;
            r_primary   <= PRIMARY_RESET;
            r_secondary <= SECONDARY_RESET;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_num   <= n_num;
                r_color <= n_color;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WHITE:     r_white     <= i_cfg_data;
                    REG_PRIMARY:   r_primary   <= i_cfg_data;
                    REG_SECONDARY: r_secondary <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/core/acctw_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on acctw_pkg for the job type.
module acctw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acctw_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output acctw_pkg::t_job o_job
);
    import acctw_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/acctw_back.sv
// Back end: cursor and ring-row tracking, one console command per cycle unless stalled.
// Takes jobs from the queue; drives the output register. Depends on acctw_pkg.
module acctw_back #(
    parameter int ROWS = 64,
    parameter int COLS = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  acctw_pkg::t_job     i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output acctw_pkg::t_out_item o_out_item
);
    import acctw_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic             r_state, n_state;
    t_job             r_job;
    logic [ROW_W-1:0] r_head, n_head, head_inc;
    logic [COL_W-1:0] r_col, n_col, col_inc;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic             adv, step, emit, stay;
    t_job             job;
    logic             at_end;

    assign adv  = !r_out_valid || !i_out_stall;
    assign job  = (r_state == ST_IDLE) ? i_job : r_job;
    assign step = adv && ((r_state == ST_BUSY) || !i_empty);
    assign o_pop = adv && (r_state == ST_IDLE) && !i_empty;

    assign head_inc = (r_head == ROW_W'(ROWS - 1)) ? '0 : r_head + 1'b1;
    assign col_inc  = r_col + 1'b1;
    assign at_end   = (r_col >= COL_W'(COLS));

    always_comb begin
        emit             = 1'b0;
        stay             = 1'b0;
        n_head           = r_head;
        n_col            = r_col;
        n_out.kind       = KIND_WRITE;
        n_out.row        = 6'(r_head);
        n_out.column     = 7'(r_col);
        n_out.glyph      = job.glyph;
        n_out.cell_color = job.color;
        n_out.last       = 1'b1;
        case (job.op)
            OP_NEWLINE: begin
                emit             = 1'b1;
                n_head           = head_inc;
                n_col            = '0;
                n_out.kind       = KIND_CLEAR;
                n_out.row        = 6'(head_inc);
                n_out.column     = '0;
                n_out.glyph      = '0;
                n_out.cell_color = job.fill;
            end
            OP_RETURN: begin
                n_col = '0;
            end
            OP_BACK: begin
                if (r_col != '0) begin
                    emit             = 1'b1;
                    n_col            = r_col - 1'b1;
                    n_out.kind       = KIND_ERASE;
                    n_out.column     = 7'(r_col - 1'b1);
                    n_out.glyph      = '0;
                    n_out.cell_color = '0;
                end
            end
            OP_PRINT, OP_TAB: begin
                emit = 1'b1;
                if (at_end) begin
                    // wrap: clear the next row; a print still has its cell to write
                    n_head           = head_inc;
                    n_col            = '0;
                    n_out.kind       = KIND_CLEAR;
                    n_out.row        = 6'(head_inc);
                    n_out.column     = '0;
                    n_out.glyph      = '0;
                    n_out.cell_color = job.fill;
                    n_out.last       = (job.op == OP_TAB);
                    stay             = (job.op == OP_PRINT);
                end else begin
                    n_col = col_inc;
                    if (job.op == OP_TAB) begin
                        // keep going until a tab stop; hitting the edge still owes a clear
                        if (col_inc >= COL_W'(COLS) || col_inc[2:0] != 3'd0) begin
                            stay       = 1'b1;
                            n_out.last = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        n_state = stay ? ST_BUSY : ST_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (step && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state <= n_state;
                r_head  <= n_head;
                r_col   <= n_col;
            end
            if (adv) begin
                r_out_valid <= step && emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/core/ansi_color_text_console_writer.sv
// Top level of the ANSI color text console writer: front end, job queue, back end.
// Depends on acctw_pkg, acctw_front, acctw_queue and acctw_back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_item  (char, default color)
//  out      | output    | o_out_valid / i_out_stall | o_out_item (console command)
//  cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// The front end takes one character per cycle while the two-entry queue has room.
// The back end issues a command per cell write, erase or row clear; a tab writes spaces
// to the next tab stop, and a wrap at the row edge adds a clear of the next row.
// Reset is synchronous and active low; it restores cursor, row, color, registers.
// An output stall holds the command register and the back end; input stalls
// only once the queue is full.
module ansi_color_text_console_writer #(
    parameter int ROWS = 64,
    parameter int COLS = 80
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  acctw_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output acctw_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import acctw_pkg::*;

    logic accept;
    logic push, pop, full, empty;
    t_job push_job, head_job;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    acctw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_push      (push),
        .o_job       (push_job)
    );

    acctw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    acctw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
